// ----- hw/rtl/rhsv_pkg.sv -----
// Shared types and constants for the 10-bit RGB to HSV pixel pipeline.
// No dependencies; imported by every rhsv_* module.
`timescale 1ns / 1ps

package rhsv_pkg;

    localparam int DATA_W         = 10;
    localparam int NUM_W          = 2 * DATA_W;          // widest dividend: 1023 * diff
    localparam int QUO_W          = DATA_W;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;
    localparam int TDATA_W        = 32;                  // 3 x 10 bits, padded to bytes

    localparam logic [DATA_W-1:0] HSV_FULL      = 10'd1023;
    localparam logic [7:0]        HSV_SECTOR    = 8'd171;
    localparam logic [DATA_W-1:0] HSV_OFS_RED   = 10'd0;
    localparam logic [DATA_W-1:0] HSV_OFS_GREEN = 10'd341;
    localparam logic [DATA_W-1:0] HSV_OFS_BLUE  = 10'd682;

    // one restoring division in flight
    typedef struct packed {
        logic [NUM_W-1:0]  rem;
        logic [DATA_W-1:0] den;
        logic [QUO_W-1:0]  quo;
    } rhsv_div_t;

    // pixel state carried through the divider stages
    typedef struct packed {
        rhsv_div_t         sat;
        rhsv_div_t         hue;
        logic              neg;     // hue difference was negative
        logic [DATA_W-1:0] ofs;     // hue sector offset
        logic              black;   // max == 0
        logic              grey;    // max == min
        logic [DATA_W-1:0] val;
    } rhsv_pix_t;

endpackage

// ----- hw/rtl/rgb_to_hsv_10bit_top.sv -----
// 10-bit RGB to HSV converter, streaming in and out one pixel word per clock while the
// output is not stalled. Each pixel passes from input to output register through two
// front stages (max/min and sector pick, then dividend setup), five divider stages
// that each resolve two quotient bits of both divisions, and one output stage.
// Throughput is one word per clock while the output does not stall; every stage carries
// its own valid bit and a stalled output back-pressures only as far as the pipeline is full.
// Depends on rhsv_pkg, rhsv_front, rhsv_div_stage, rhsv_out.
`timescale 1ns / 1ps

module rgb_to_hsv_10bit_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [rhsv_pkg::TDATA_W-1:0] s_axis_tdata,   // red[9:0], green[19:10], blue[29:20]
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [rhsv_pkg::TDATA_W-1:0] m_axis_tdata    // hue[9:0], saturation[19:10],
                                                         // brightness[29:20]
);
    import rhsv_pkg::*;

    logic              valid [DIV_STAGES+1];
    logic              ready [DIV_STAGES+1];
    rhsv_pix_t         pix   [DIV_STAGES+1];
    logic [DATA_W-1:0] hue;
    logic [DATA_W-1:0] saturation;
    logic [DATA_W-1:0] brightness;

    rhsv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .red       (s_axis_tdata[DATA_W-1:0]),
        .green     (s_axis_tdata[2*DATA_W-1:DATA_W]),
        .blue      (s_axis_tdata[3*DATA_W-1:2*DATA_W]),
        .out_valid (valid[0]),
        .out_ready (ready[0]),
        .out_pix   (pix[0])
    );

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        rhsv_div_stage #(
            .STAGE (i)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid[i]),
            .in_ready  (ready[i]),
            .in_pix    (pix[i]),
            .out_valid (valid[i+1]),
            .out_ready (ready[i+1]),
            .out_pix   (pix[i+1])
        );
    end

    rhsv_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (valid[DIV_STAGES]),
        .in_ready   (ready[DIV_STAGES]),
        .in_pix     (pix[DIV_STAGES]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

    assign m_axis_tdata = {{(TDATA_W-3*DATA_W){1'b0}}, brightness, saturation, hue};

endmodule

// ----- hw/rtl/rhsv_front.sv -----
// Front end: max/min/sector pick (stage 1), then dividend/divisor setup (stage 2).
// Depends on rhsv_pkg.
`timescale 1ns / 1ps

module rhsv_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [rhsv_pkg::DATA_W-1:0] red,
    input  logic [rhsv_pkg::DATA_W-1:0] green,
    input  logic [rhsv_pkg::DATA_W-1:0] blue,
    output logic                       out_valid,
    input  logic                       out_ready,
    output rhsv_pkg::rhsv_pix_t        out_pix
);
    import rhsv_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic [DATA_W-1:0] diff;
        logic [DATA_W:0]   dif_sgn;   // signed difference of the other two channels
        logic [DATA_W-1:0] ofs;
    } rhsv_sort_t;

    // stage 1
    logic              s1_valid_reg;
    rhsv_sort_t        s1_reg;
    rhsv_sort_t        s1_next;
    logic              s1_ready;
    logic [DATA_W-1:0] mx;
    logic [DATA_W-1:0] mn;

    // stage 2
    logic              s2_valid_reg;
    rhsv_pix_t         s2_reg;
    rhsv_pix_t         s2_next;
    logic              s2_ready;
    logic [DATA_W:0]   mag_full;
    logic [DATA_W-1:0] mag;
    logic [17:0]       hue_prod;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb
    begin
        mx = (red > green) ? ((red > blue) ? red : blue) : ((green > blue) ? green : blue);
        mn = (red < green) ? ((red < blue) ? red : blue) : ((green < blue) ? green : blue);
        s1_next.val  = mx;
        s1_next.diff = mx - mn;
        // ties: red first, then green
        if (mx == red)
        begin
            s1_next.ofs     = HSV_OFS_RED;
            s1_next.dif_sgn = {1'b0, green} - {1'b0, blue};
        end
        else if (mx == green)
        begin
            s1_next.ofs     = HSV_OFS_GREEN;
            s1_next.dif_sgn = {1'b0, blue} - {1'b0, red};
        end
        else
        begin
            s1_next.ofs     = HSV_OFS_BLUE;
            s1_next.dif_sgn = {1'b0, red} - {1'b0, green};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
            s1_reg <= s1_next;
    end

    always_comb
    begin
        mag_full = s1_reg.dif_sgn[DATA_W] ? (~s1_reg.dif_sgn + 1'b1) : s1_reg.dif_sgn;
        mag      = mag_full[DATA_W-1:0];
        hue_prod = mag * HSV_SECTOR;

        s2_next.val   = s1_reg.val;
        s2_next.ofs   = s1_reg.ofs;
        s2_next.neg   = s1_reg.dif_sgn[DATA_W];
        s2_next.black = (s1_reg.val == '0);
        s2_next.grey  = (s1_reg.diff == '0);

        // 1023 * diff = (diff << 10) - diff
        s2_next.sat.rem = {s1_reg.diff, {DATA_W{1'b0}}} - {{DATA_W{1'b0}}, s1_reg.diff};
        s2_next.sat.den = s2_next.black ? DATA_W'(1) : s1_reg.val;
        s2_next.sat.quo = '0;

        s2_next.hue.rem = {{(NUM_W-18){1'b0}}, hue_prod};
        s2_next.hue.den = s2_next.grey ? DATA_W'(1) : s1_reg.diff;
        s2_next.hue.quo = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_ready)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
            s2_reg <= s2_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_pix   = s2_reg;

endmodule

// ----- hw/rtl/rhsv_div_stage.sv -----
// One divider stage: BITS_PER_STAGE restoring steps on both the saturation
// and hue divisions. Depends on rhsv_pkg.
`timescale 1ns / 1ps

module rhsv_div_stage #(
    parameter int STAGE = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rhsv_pkg::rhsv_pix_t in_pix,
    output logic                out_valid,
    input  logic                out_ready,
    output rhsv_pkg::rhsv_pix_t out_pix
);
    import rhsv_pkg::*;

    logic      valid_reg;
    rhsv_pix_t pix_reg;
    rhsv_pix_t pix_next;

    function automatic rhsv_div_t div_step(rhsv_div_t x, int bit_idx);
        rhsv_div_t        y;
        logic [NUM_W-1:0] sub;
        y   = x;
        sub = {{(NUM_W-DATA_W){1'b0}}, x.den} << bit_idx;
        if (x.rem >= sub)
        begin
            y.rem          = x.rem - sub;
            y.quo[bit_idx] = 1'b1;
        end
        return y;
    endfunction

    always_comb
    begin
        pix_next = in_pix;
        for (int j = 0; j < BITS_PER_STAGE; j++)
        begin
            pix_next.sat = div_step(pix_next.sat, QUO_W - 1 - STAGE * BITS_PER_STAGE - j);
            pix_next.hue = div_step(pix_next.hue, QUO_W - 1 - STAGE * BITS_PER_STAGE - j);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            pix_reg <= pix_next;
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

endmodule

// ----- hw/rtl/rhsv_out.sv -----
// Output stage: applies sign, sector offset and black/grey overrides,
// and holds the result word. Depends on rhsv_pkg.
`timescale 1ns / 1ps

module rhsv_out (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  rhsv_pkg::rhsv_pix_t         in_pix,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rhsv_pkg::DATA_W-1:0] hue,
    output logic [rhsv_pkg::DATA_W-1:0] saturation,
    output logic [rhsv_pkg::DATA_W-1:0] brightness
);
    import rhsv_pkg::*;

    logic              valid_reg;
    logic [DATA_W-1:0] hue_reg;
    logic [DATA_W-1:0] sat_reg;
    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] hue_next;
    logic [DATA_W-1:0] sat_next;
    logic [DATA_W-1:0] hue_term;

    always_comb
    begin
        // negative hue wraps mod 1024 via 10-bit arithmetic
        hue_term = in_pix.neg ? (~in_pix.hue.quo + 1'b1) : in_pix.hue.quo;
        hue_next = in_pix.grey ? '0 : (in_pix.ofs + hue_term);
        sat_next = in_pix.black ? HSV_FULL : in_pix.sat.quo;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= in_pix.val;
        end
    end

    assign out_valid  = valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = val_reg;

endmodule

// ----- hw/rtl/rhsv_checker.sv -----
// Port-level checks for rgb_to_hsv_10bit_top, attached by bind.
// Depends on rhsv_pkg.
`timescale 1ns / 1ps

module rhsv_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [rhsv_pkg::TDATA_W-1:0] m_axis_tdata
);
    import rhsv_pkg::*;

    // output word must hold while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // input back-pressure only when a finished word is waiting
    a_bp_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output stall");

    // black pixel: full saturation, zero hue
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[3*DATA_W-1:2*DATA_W] == '0)
        |-> (m_axis_tdata[2*DATA_W-1:DATA_W] == HSV_FULL)
            && (m_axis_tdata[DATA_W-1:0] == '0))
        else $error("black pixel result wrong");

endmodule

bind rgb_to_hsv_10bit_top rhsv_checker u_rhsv_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- verif/rgb_to_hsv_10bit_top_test.sv -----
// Self-checking testbench for rgb_to_hsv_10bit_top: directed and random pixels on the
// input stream, every output word compared with its typed-in or predicted HSV value.
// Depends on rhsv_pkg and rgb_to_hsv_10bit_top.
`timescale 1ns / 1ps

module rgb_to_hsv_10bit_top_test;

    localparam int SAT_FULL     = 1023;
    localparam int HUE_SPAN     = 171;
    localparam int HUE_OFS_GRN  = 341;
    localparam int HUE_OFS_BLU  = 682;
    localparam int RANDOM_PIX   = 1150;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int NUM_DIRECTED = 24;

    typedef struct packed {
        logic [9:0] hue;
        logic [9:0] sat;
        logic [9:0] val;
    } pixel_hsv_t;

    // known = 1: hue/sat/val typed in below, otherwise taken from the predictor
    typedef struct packed {
        logic [9:0] red;
        logic [9:0] green;
        logic [9:0] blue;
        logic       known;
        logic [9:0] hue;
        logic [9:0] sat;
        logic [9:0] val;
    } pixel_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [rhsv_pkg::TDATA_W-1:0] s_axis_tdata = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [rhsv_pkg::TDATA_W-1:0] m_axis_tdata;

    pixel_hsv_t hsv_pending[$];
    int         fail_cnt = 0;
    int         burst_left = 1;
    int         idle_cycles = 0;

    pixel_row_t pixel_rows [0:NUM_DIRECTED-1] = '{
        '{10'd0,    10'd0,    10'd0,    1'b1, 10'd0,   10'd1023, 10'd0},    // black
        '{10'd1023, 10'd1023, 10'd1023, 1'b1, 10'd0,   10'd0,    10'd1023}, // white
        '{10'd512,  10'd512,  10'd512,  1'b1, 10'd0,   10'd0,    10'd512},  // grey
        '{10'd1,    10'd1,    10'd1,    1'b1, 10'd0,   10'd0,    10'd1},
        '{10'd1023, 10'd0,    10'd0,    1'b1, 10'd0,   10'd1023, 10'd1023},
        '{10'd0,    10'd1023, 10'd0,    1'b1, 10'd341, 10'd1023, 10'd1023},
        '{10'd0,    10'd0,    10'd1023, 1'b1, 10'd682, 10'd1023, 10'd1023},
        '{10'd1023, 10'd1023, 10'd0,    1'b1, 10'd171, 10'd1023, 10'd1023}, // r/g tie
        '{10'd0,    10'd1023, 10'd1023, 1'b1, 10'd512, 10'd1023, 10'd1023}, // g/b tie
        '{10'd1023, 10'd0,    10'd1023, 1'b1, 10'd853, 10'd1023, 10'd1023}, // hue -171
        '{10'd1,    10'd0,    10'd0,    1'b1, 10'd0,   10'd1023, 10'd1},
        '{10'd0,    10'd0,    10'd1,    1'b1, 10'd682, 10'd1023, 10'd1},
        '{10'd1023, 10'd0,    10'd1022, 1'b0, 10'd0,   10'd0,    10'd0},
        '{10'd1023, 10'd1022, 10'd1023, 1'b0, 10'd0,   10'd0,    10'd0},
        '{10'd1023, 10'd1,    10'd0,    1'b0, 10'd0,   10'd0,    10'd0},
        '{10'd1,    10'd1023, 10'd0,    1'b0, 10'd0,   10'd0,    10'd0},
        '{10'd0,    10'd1,    10'd1023, 1'b0, 10'd0,   10'd0,    10'd0},
        '{10'd1022, 10'd1023, 10'd1023, 1'b0, 10'd0,   10'd0,    10'd0},
        '{10'd1023, 10'd512,  10'd511,  1'b0, 10'd0,   10'd0,    10'd0},
        '{10'd682,  10'd341,  10'd1023, 1'b0, 10'd0,   10'd0,    10'd0},
        '{10'h155,  10'h2AA,  10'h3FF,  1'b0, 10'd0,   10'd0,    10'd0},
        '{10'h2AA,  10'h155,  10'd0,    1'b0, 10'd0,   10'd0,    10'd0},
        '{10'd1023, 10'd1023, 10'd1022, 1'b0, 10'd0,   10'd0,    10'd0},
        '{10'd2,    10'd1,    10'd0,    1'b0, 10'd0,   10'd0,    10'd0}
    };

    rgb_to_hsv_10bit_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic pixel_hsv_t rgb_to_hsv(input logic [9:0] red, input logic [9:0] green,
                                              input logic [9:0] blue);
        int         r, g, b, mx, mn, diff, hue, sat;
        pixel_hsv_t res;
        r = red;
        g = green;
        b = blue;
        mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
        mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
        diff = mx - mn;
        sat = (mx == 0) ? SAT_FULL : (SAT_FULL * diff) / mx;
        // signed int division truncates toward zero; ties go red, then green
        if (diff == 0)
            hue = 0;
        else if (mx == r)
            hue = (HUE_SPAN * (g - b)) / diff;
        else if (mx == g)
            hue = HUE_OFS_GRN + (HUE_SPAN * (b - r)) / diff;
        else
            hue = HUE_OFS_BLU + (HUE_SPAN * (r - g)) / diff;
        res.hue = hue[9:0];
        res.sat = sat[9:0];
        res.val = mx[9:0];
        return res;
    endfunction

    // called at a falling edge; returns at a falling edge after the word is taken
    task automatic offer_pixel(input logic [9:0] red, input logic [9:0] green,
                               input logic [9:0] blue, input pixel_hsv_t want);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, blue, green, red};
        do
            @(posedge clk);
        while (!s_axis_tready);
        hsv_pending.push_back(want);
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic pick_pixel(output logic [9:0] red, output logic [9:0] green,
                              output logic [9:0] blue);
        logic [9:0] corner [0:7];
        logic [9:0] top, lo;
        int         sel;
        corner = '{10'd0, 10'd1, 10'd2, 10'd511, 10'd512, 10'd1021, 10'd1022, 10'd1023};
        red   = 10'($urandom);
        green = 10'($urandom);
        blue  = 10'($urandom);
        case ($urandom_range(0, 9))
            4:  // two channels share the maximum
            begin
                top = 10'($urandom);
                lo  = 10'($urandom_range(0, top));
                sel = $urandom_range(0, 2);
                red   = (sel == 0) ? lo : top;
                green = (sel == 1) ? lo : top;
                blue  = (sel == 2) ? lo : top;
            end
            5:
            begin
                green = red;
                blue  = red;
            end
            6:
            begin
                red   = corner[$urandom_range(0, 7)];
                green = corner[$urandom_range(0, 7)];
                blue  = corner[$urandom_range(0, 7)];
            end
            7:
            begin
                red   = 10'($urandom_range(0, 3));
                green = 10'($urandom_range(0, 3));
                blue  = 10'($urandom_range(0, 3));
            end
            8:  // red sector with blue above green: hue wraps below zero
            begin
                red   = 10'($urandom_range(2, 1023));
                blue  = 10'($urandom_range(1, red));
                green = 10'($urandom_range(0, blue - 1));
            end
            9:  // max - min of at most one
            begin
                lo    = 10'($urandom_range(0, 1022));
                red   = lo + 10'($urandom_range(0, 1));
                green = lo + 10'($urandom_range(0, 1));
                blue  = lo + 10'($urandom_range(0, 1));
            end
            default:
            begin
            end
        endcase
    endtask

    initial
    begin
        logic [9:0] red, green, blue;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (pixel_rows[i])
        begin
            if (pixel_rows[i].known)
                offer_pixel(pixel_rows[i].red, pixel_rows[i].green, pixel_rows[i].blue,
                            '{pixel_rows[i].hue, pixel_rows[i].sat, pixel_rows[i].val});
            else
                offer_pixel(pixel_rows[i].red, pixel_rows[i].green, pixel_rows[i].blue,
                            rgb_to_hsv(pixel_rows[i].red, pixel_rows[i].green,
                                       pixel_rows[i].blue));
        end
        repeat (RANDOM_PIX)
        begin
            pick_pixel(red, green, blue);
            offer_pixel(red, green, blue, rgb_to_hsv(red, green, blue));
        end
        s_axis_tvalid <= 1'b0;
        while (hsv_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
            $display("rgb_to_hsv_10bit_top test passed");
        else
            $display("rgb_to_hsv_10bit_top test failed");
        $finish;
    end

    // output side: ready for a while, then one long hold so the pipe fills and
    // pushes back on the input, then a random mix of patterns
    initial
    begin
        int n;
        @(posedge rst_n);
        @(negedge clk);
        m_axis_tready <= 1'b1;
        repeat (50) @(negedge clk);
        m_axis_tready <= 1'b0;
        repeat (150) @(negedge clk);
        forever
        begin
            n = $urandom_range(10, 60);
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    m_axis_tready <= 1'b1;
                    repeat (n) @(negedge clk);
                end
                3, 4, 5, 6:
                    repeat (n)
                    begin
                        m_axis_tready <= ($urandom_range(0, 3) != 0);
                        @(negedge clk);
                    end
                7:
                begin
                    m_axis_tready <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(negedge clk);
                end
                8:
                    repeat (n)
                    begin
                        m_axis_tready <= ~m_axis_tready;
                        @(negedge clk);
                    end
                default:
                begin
                    m_axis_tready <= ($urandom_range(0, 4) != 0);
                    repeat ($urandom_range(1, 40)) @(negedge clk);
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        pixel_hsv_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (hsv_pending.size() == 0)
            begin
                $error("output word 0x%h with no pixel pending", m_axis_tdata);
                fail_cnt++;
            end
            else
            begin
                want = hsv_pending.pop_front();
                if (m_axis_tdata[9:0] !== want.hue)
                begin
                    $error("hue: expected %0d, got %0d", want.hue, m_axis_tdata[9:0]);
                    fail_cnt++;
                end
                if (m_axis_tdata[19:10] !== want.sat)
                begin
                    $error("saturation: expected %0d, got %0d", want.sat, m_axis_tdata[19:10]);
                    fail_cnt++;
                end
                if (m_axis_tdata[29:20] !== want.val)
                begin
                    $error("brightness: expected %0d, got %0d", want.val, m_axis_tdata[29:20]);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog: no word moving on either side for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("rgb_to_hsv_10bit_top test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
